// ----- hw/rtl/ect_pkg.sv -----
// Shared constants, codes and controller/datapath interface types
// for the ear-clipping triangulator. No dependencies.
`timescale 1ns / 1ps

package ect_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int COORD_BITS   = 12;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int VTX_W        = 2 * COORD_BITS;
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int STATUS_W     = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_TRIANGLE = 2'd0,
        ST_NO_EAR   = 2'd1,
        ST_TOO_FEW  = 2'd2
    } status_t;

    typedef enum logic [1:0] {RR_PREV, RR_CUR, RR_NEXT, RR_MOVE} ring_rsel_t;
    typedef enum logic {RW_INIT, RW_MOVE} ring_wsel_t;
    typedef enum logic [1:0] {VR_A, VR_B, VR_C, VR_P} vtx_rsel_t;
    typedef enum logic [1:0] {CS_ABC, CS_ABP, CS_BCP, CS_CAP} cross_sel_t;

    typedef struct packed {
        logic       take;
        logic       clr_poly;
        logic       i_clr;
        logic       i_inc;
        logic       p_clr;
        logic       p_inc;
        logic       p_from_i;
        logic       rc_load_n;
        logic       rc_dec;
        logic       ring_we;
        ring_wsel_t ring_wsel;
        ring_rsel_t ring_rsel;
        logic       ld_ia;
        logic       ld_ib;
        logic       ld_ic;
        vtx_rsel_t  vtx_rsel;
        logic       ld_a;
        logic       ld_b;
        logic       ld_c;
        logic       ld_p;
        cross_sel_t cross_sel;
        logic       vote_shift;
        logic       out_load;
        status_t    out_status;
        logic       out_last;
    } cmd_t;

    typedef struct packed {
        logic n_lt3;
        logic p_at_n;
        logic p_at_rc;
        logic i_last;
        logic cross_neg;
        logic enclosed;
        logic rc_is3;
        logic out_free;
    } stat_t;

endpackage

// ----- hw/rtl/ect_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module ect_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/ect_datapath.sv -----
// Datapath of the triangulator: vertex and ring memories, counters, cross-product
// unit, point-in-triangle votes and the output register. Uses ect_pkg and ect_ram.
`timescale 1ns / 1ps

module ect_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ect_pkg::cmd_t                    cmd,
    output ect_pkg::stat_t                   stat,
    input  logic [ect_pkg::COORD_BITS-1:0]   vertex_x,
    input  logic [ect_pkg::COORD_BITS-1:0]   vertex_y,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ect_pkg::COORD_BITS-1:0]   corner_a_x,
    output logic [ect_pkg::COORD_BITS-1:0]   corner_a_y,
    output logic [ect_pkg::COORD_BITS-1:0]   corner_b_x,
    output logic [ect_pkg::COORD_BITS-1:0]   corner_b_y,
    output logic [ect_pkg::COORD_BITS-1:0]   corner_c_x,
    output logic [ect_pkg::COORD_BITS-1:0]   corner_c_y,
    output logic                             last_triangle,
    output logic [ect_pkg::STATUS_W-1:0]     status,
    output logic                             overflowed
);

    localparam int CB = ect_pkg::COORD_BITS;
    localparam int IW = ect_pkg::IDX_W;
    localparam int CW = ect_pkg::CNT_W;
    localparam int VW = ect_pkg::VTX_W;
    localparam int DW = ect_pkg::DIFF_W;
    localparam int PW = ect_pkg::PROD_W;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [IW-1:0] i_reg, i_next;
    logic [CW-1:0] p_reg, p_next;
    logic [CW-1:0] rc_reg, rc_next;
    logic [IW-1:0] ia_reg, ib_reg, ic_reg;
    logic [VW-1:0] a_reg, b_reg, c_reg, pt_reg;
    logic signed [PW-1:0] prod1_reg, prod2_reg;
    logic          neg_reg;
    logic [2:0]    vote_reg;
    logic          out_valid_reg, out_valid_next;
    logic [CB-1:0] oax_reg, oay_reg, obx_reg, oby_reg, ocx_reg, ocy_reg;
    logic          olast_reg;
    logic [ect_pkg::STATUS_W-1:0] ostatus_reg;
    logic          oovf_reg;

    logic          has_room;
    logic [CW-1:0] rc_m1, p_m1;
    logic          vtx_we;
    logic [VW-1:0] vtx_rdata;
    logic [IW-1:0] vtx_raddr;
    logic          ring_we;
    logic [IW-1:0] ring_waddr, ring_wdata, ring_raddr, ring_rdata;
    logic [VW-1:0] u_v, v_v, w_v;
    logic signed [DW-1:0] d1x, d1y, d2x, d2y;
    logic          out_ok;

    assign has_room = count_reg < CW'(ect_pkg::MAX_VERTICES);
    assign rc_m1    = rc_reg - CW'(1);
    assign p_m1     = p_reg - CW'(1);
    assign vtx_we   = cmd.take && has_room;

    // Vertex store, x in the low half
    ect_ram #(.WIDTH(VW), .DEPTH(ect_pkg::MAX_VERTICES)) u_vtx_ram (
        .clk   (clk),
        .we    (vtx_we),
        .waddr (count_reg[IW-1:0]),
        .wdata ({vertex_y, vertex_x}),
        .raddr (vtx_raddr),
        .rdata (vtx_rdata)
    );

    // Ring of remaining vertex indices
    ect_ram #(.WIDTH(IW), .DEPTH(ect_pkg::MAX_VERTICES)) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // Select vertex read address
    always_comb
    begin
        unique case (cmd.vtx_rsel)
            ect_pkg::VR_A: vtx_raddr = ia_reg;
            ect_pkg::VR_B: vtx_raddr = ib_reg;
            ect_pkg::VR_C: vtx_raddr = ic_reg;
            default:       vtx_raddr = p_reg[IW-1:0];
        endcase
    end

    // Select ring read address, wrapping at both ends
    always_comb
    begin
        unique case (cmd.ring_rsel)
            ect_pkg::RR_PREV: ring_raddr = (i_reg == '0) ? rc_m1[IW-1:0] : i_reg - IW'(1);
            ect_pkg::RR_CUR:  ring_raddr = i_reg;
            ect_pkg::RR_NEXT: ring_raddr = stat.i_last ? '0 : i_reg + IW'(1);
            default:          ring_raddr = p_reg[IW-1:0];
        endcase
    end

    // Ring writes: identity fill or shift down by one
    assign ring_we    = cmd.ring_we;
    assign ring_waddr = (cmd.ring_wsel == ect_pkg::RW_INIT) ? p_reg[IW-1:0] : p_m1[IW-1:0];
    assign ring_wdata = (cmd.ring_wsel == ect_pkg::RW_INIT) ? p_reg[IW-1:0] : ring_rdata;

    // Cross-product operands U, V, W
    always_comb
    begin
        unique case (cmd.cross_sel)
            ect_pkg::CS_ABC: begin u_v = a_reg; v_v = b_reg; w_v = c_reg;  end
            ect_pkg::CS_ABP: begin u_v = a_reg; v_v = b_reg; w_v = pt_reg; end
            ect_pkg::CS_BCP: begin u_v = b_reg; v_v = c_reg; w_v = pt_reg; end
            default:         begin u_v = c_reg; v_v = a_reg; w_v = pt_reg; end
        endcase
    end

    assign d1x = signed'({1'b0, v_v[CB-1:0]})  - signed'({1'b0, u_v[CB-1:0]});
    assign d1y = signed'({1'b0, v_v[VW-1:CB]}) - signed'({1'b0, u_v[VW-1:CB]});
    assign d2x = signed'({1'b0, w_v[CB-1:0]})  - signed'({1'b0, v_v[CB-1:0]});
    assign d2y = signed'({1'b0, w_v[VW-1:CB]}) - signed'({1'b0, v_v[VW-1:CB]});

    // Counter next values
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.clr_poly)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (cmd.take)
        begin
            if (has_room)
            begin
                count_next = count_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        i_next = i_reg;
        if (cmd.i_clr)
        begin
            i_next = '0;
        end
        else if (cmd.i_inc)
        begin
            i_next = i_reg + IW'(1);
        end

        p_next = p_reg;
        if (cmd.p_clr)
        begin
            p_next = '0;
        end
        else if (cmd.p_from_i)
        begin
            p_next = CW'(i_reg) + CW'(1);
        end
        else if (cmd.p_inc)
        begin
            p_next = p_reg + CW'(1);
        end

        rc_next = rc_reg;
        if (cmd.rc_load_n)
        begin
            rc_next = count_reg;
        end
        else if (cmd.rc_dec)
        begin
            rc_next = rc_m1;
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold control counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            p_reg         <= '0;
            rc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            i_reg         <= i_next;
            p_reg         <= p_next;
            rc_reg        <= rc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_ok = (cmd.out_status == ect_pkg::ST_TRIANGLE);

    // Payload registers: corners, products, votes, result
    always_ff @(posedge clk)
    begin
        if (cmd.ld_ia) ia_reg <= ring_rdata;
        if (cmd.ld_ib) ib_reg <= ring_rdata;
        if (cmd.ld_ic) ic_reg <= ring_rdata;
        if (cmd.ld_a)  a_reg  <= vtx_rdata;
        if (cmd.ld_b)  b_reg  <= vtx_rdata;
        if (cmd.ld_c)  c_reg  <= vtx_rdata;
        if (cmd.ld_p)  pt_reg <= vtx_rdata;
        prod1_reg <= PW'(d1x) * PW'(d2y);
        prod2_reg <= PW'(d1y) * PW'(d2x);
        neg_reg   <= prod1_reg < prod2_reg;
        if (cmd.vote_shift)
        begin
            vote_reg <= {vote_reg[1:0], neg_reg};
        end
        if (cmd.out_load)
        begin
            oax_reg     <= out_ok ? a_reg[CB-1:0]  : '0;
            oay_reg     <= out_ok ? a_reg[VW-1:CB] : '0;
            obx_reg     <= out_ok ? b_reg[CB-1:0]  : '0;
            oby_reg     <= out_ok ? b_reg[VW-1:CB] : '0;
            ocx_reg     <= out_ok ? c_reg[CB-1:0]  : '0;
            ocy_reg     <= out_ok ? c_reg[VW-1:CB] : '0;
            olast_reg   <= cmd.out_last;
            ostatus_reg <= cmd.out_status;
            oovf_reg    <= ovf_reg;
        end
    end

    // Status to the controller
    assign stat.n_lt3     = count_reg < CW'(3);
    assign stat.p_at_n    = p_reg == count_reg;
    assign stat.p_at_rc   = p_reg == rc_reg;
    assign stat.i_last    = CW'(i_reg) == rc_m1;
    assign stat.cross_neg = neg_reg;
    assign stat.enclosed  = (vote_reg == 3'b000) || (vote_reg == 3'b111);
    assign stat.rc_is3    = rc_reg == CW'(3);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign corner_a_x    = oax_reg;
    assign corner_a_y    = oay_reg;
    assign corner_b_x    = obx_reg;
    assign corner_b_y    = oby_reg;
    assign corner_c_x    = ocx_reg;
    assign corner_c_y    = ocy_reg;
    assign last_triangle = olast_reg;
    assign status        = ostatus_reg;
    assign overflowed    = oovf_reg;

endmodule

// ----- hw/rtl/ect_ctrl.sv -----
// Controller state machine of the triangulator: sequences loading, ring set-up,
// ear tests, point tests, emission and ring compaction. Uses ect_pkg.
`timescale 1ns / 1ps

module ect_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           last_vertex,
    input  ect_pkg::stat_t stat,
    output ect_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_INIT, S_R0, S_R1, S_R2, S_R3,
        S_V0, S_V1, S_V2, S_V3, S_E0, S_E1, S_E2,
        S_PRD, S_PLAT, S_T0, S_T1, S_T2, S_T3, S_T4, S_T5,
        S_EMIT, S_MVRD, S_MVWR, S_ERR
    } state_t;

    state_t           state_reg, state_next;
    ect_pkg::status_t err_reg, err_next;
    logic             reject;

    assign in_ready = (state_reg == S_IDLE);

    // Decode commands and next state
    always_comb
    begin
        cmd            = '0;
        cmd.ring_wsel  = ect_pkg::RW_INIT;
        cmd.ring_rsel  = ect_pkg::RR_CUR;
        cmd.vtx_rsel   = ect_pkg::VR_A;
        cmd.cross_sel  = ect_pkg::CS_ABC;
        cmd.out_status = ect_pkg::ST_TRIANGLE;
        state_next     = state_reg;
        err_next       = err_reg;
        reject         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (last_vertex) state_next = S_START;
                end
            end
            S_START:
            begin
                if (stat.n_lt3)
                begin
                    err_next   = ect_pkg::ST_TOO_FEW;
                    state_next = S_ERR;
                end
                else
                begin
                    cmd.p_clr  = 1'b1;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                if (stat.p_at_n)
                begin
                    cmd.rc_load_n = 1'b1;
                    cmd.i_clr     = 1'b1;
                    state_next    = S_R0;
                end
                else
                begin
                    cmd.ring_we = 1'b1;
                    cmd.p_inc   = 1'b1;
                end
            end
            S_R0: begin cmd.ring_rsel = ect_pkg::RR_PREV; state_next = S_R1; end
            S_R1: begin cmd.ring_rsel = ect_pkg::RR_CUR; cmd.ld_ia = 1'b1; state_next = S_R2; end
            S_R2: begin cmd.ring_rsel = ect_pkg::RR_NEXT; cmd.ld_ib = 1'b1; state_next = S_R3; end
            S_R3: begin cmd.ld_ic = 1'b1; state_next = S_V0; end
            S_V0: begin cmd.vtx_rsel = ect_pkg::VR_A; state_next = S_V1; end
            S_V1: begin cmd.vtx_rsel = ect_pkg::VR_B; cmd.ld_a = 1'b1; state_next = S_V2; end
            S_V2: begin cmd.vtx_rsel = ect_pkg::VR_C; cmd.ld_b = 1'b1; state_next = S_V3; end
            S_V3: begin cmd.ld_c = 1'b1; state_next = S_E0; end
            S_E0: begin cmd.cross_sel = ect_pkg::CS_ABC; state_next = S_E1; end
            S_E1: state_next = S_E2;
            S_E2:
            begin
                if (!stat.cross_neg)
                begin
                    reject = 1'b1;
                end
                else
                begin
                    cmd.p_clr  = 1'b1;
                    state_next = S_PRD;
                end
            end
            S_PRD:
            begin
                if (stat.p_at_n)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.vtx_rsel = ect_pkg::VR_P;
                    state_next   = S_PLAT;
                end
            end
            S_PLAT: begin cmd.ld_p = 1'b1; state_next = S_T0; end
            S_T0: begin cmd.cross_sel = ect_pkg::CS_ABP; state_next = S_T1; end
            S_T1: begin cmd.cross_sel = ect_pkg::CS_BCP; state_next = S_T2; end
            S_T2:
            begin
                cmd.cross_sel  = ect_pkg::CS_CAP;
                cmd.vote_shift = 1'b1;
                state_next     = S_T3;
            end
            S_T3: begin cmd.vote_shift = 1'b1; state_next = S_T4; end
            S_T4: begin cmd.vote_shift = 1'b1; state_next = S_T5; end
            S_T5:
            begin
                if (stat.enclosed)
                begin
                    reject = 1'b1;
                end
                else
                begin
                    cmd.p_inc  = 1'b1;
                    state_next = S_PRD;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = stat.rc_is3;
                    cmd.p_from_i = 1'b1;
                    state_next   = S_MVRD;
                end
            end
            S_MVRD:
            begin
                if (stat.p_at_rc)
                begin
                    cmd.rc_dec = 1'b1;
                    cmd.i_clr  = 1'b1;
                    if (stat.rc_is3)
                    begin
                        cmd.clr_poly = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_R0;
                    end
                end
                else
                begin
                    cmd.ring_rsel = ect_pkg::RR_MOVE;
                    state_next    = S_MVWR;
                end
            end
            S_MVWR:
            begin
                cmd.ring_we   = 1'b1;
                cmd.ring_wsel = ect_pkg::RW_MOVE;
                cmd.p_inc     = 1'b1;
                state_next    = S_MVRD;
            end
            S_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = err_reg;
                    cmd.out_last   = 1'b1;
                    cmd.clr_poly   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // Drop this tip: try the next one, or give up at the end of the ring
        if (reject)
        begin
            if (stat.i_last)
            begin
                err_next   = ect_pkg::ST_NO_EAR;
                state_next = S_ERR;
            end
            else
            begin
                cmd.i_inc  = 1'b1;
                state_next = S_R0;
            end
        end
    end

    // Hold state and error code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            err_reg   <= ect_pkg::ST_TRIANGLE;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ----- hw/rtl/ear_clip_triangulator.sv -----
// Top level of the ear-clipping triangulator: controller plus datapath.
// Depends on ect_pkg, ect_ctrl, ect_datapath (and ect_ram through it).
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_valid/in_ready, vertex_x/y, last   | into block
//   out     | out_valid/out_ready, corners, status  | out of block
//
// Vertices load back to back.
// After the last vertex the ring is built; then for each tip tried its corners are
// read, the ear is tested, and every stored vertex is tested against it; an ear is
// emitted and removed by shifting the later ring entries down. An error ends the
// polygon with a single status result. The cross-product unit is shared; memory reads are registered.
// Input is not taken while a polygon is being clipped. A stalled output holds
// the controller at the emit or error step. Reset is asynchronous, active low.
`timescale 1ns / 1ps

module ear_clip_triangulator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ect_pkg::COORD_BITS-1:0]   vertex_x,
    input  logic [ect_pkg::COORD_BITS-1:0]   vertex_y,
    input  logic                             last_vertex,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ect_pkg::COORD_BITS-1:0]   corner_a_x,
    output logic [ect_pkg::COORD_BITS-1:0]   corner_a_y,
    output logic [ect_pkg::COORD_BITS-1:0]   corner_b_x,
    output logic [ect_pkg::COORD_BITS-1:0]   corner_b_y,
    output logic [ect_pkg::COORD_BITS-1:0]   corner_c_x,
    output logic [ect_pkg::COORD_BITS-1:0]   corner_c_y,
    output logic                             last_triangle,
    output logic [ect_pkg::STATUS_W-1:0]     status,
    output logic                             overflowed
);

    ect_pkg::cmd_t  cmd;
    ect_pkg::stat_t stat;

    ect_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .last_vertex (last_vertex),
        .stat        (stat),
        .cmd         (cmd)
    );

    ect_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .vertex_x      (vertex_x),
        .vertex_y      (vertex_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .corner_a_x    (corner_a_x),
        .corner_a_y    (corner_a_y),
        .corner_b_x    (corner_b_x),
        .corner_b_y    (corner_b_y),
        .corner_c_x    (corner_c_x),
        .corner_c_y    (corner_c_y),
        .last_triangle (last_triangle),
        .status        (status),
        .overflowed    (overflowed)
    );

endmodule
